>>> sv/speed_pi_controller_assert.svh
// assertion macros for the RTL
`ifndef SPEED_PI_CONTROLLER_ASSERT_SVH
`define SPEED_PI_CONTROLLER_ASSERT_SVH

// check a property at every rising clock edge outside reset
`define SPC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check a property at every rising clock edge, reset included
`define SPC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/spc_pkg.sv
`default_nettype none

package spc_pkg;

    localparam int PULSE_W    = 16;
    localparam int REF_W      = 16;
    localparam int GAIN_W     = 8;
    localparam int RATE_W     = 8;
    localparam int DRIVE_W    = 7;
    localparam int SPEED_W    = 16;
    localparam int INTEG_W    = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int PC_W       = 4;
    localparam int ERR_W      = 18;
    localparam int EMAG_W     = 17;
    localparam int MAG_W      = 24;
    localparam int Q10_W      = 21;
    localparam int TERM_W     = 22;
    localparam int ITERM_W    = 25;
    localparam int CTRL_W     = 26;
    localparam int CNT_W      = 5;
    localparam int RPROD_W    = 56;
    localparam int RECIP_SHIFT = 35;

    localparam logic [31:0]      RECIP10   = 32'hCCCC_CCCD;
    localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(MAG_W);

    localparam logic [REF_W-1:0]  SPEED_REF_RESET  = 16'd80;
    localparam logic [GAIN_W-1:0] PROP_GAIN_RESET  = 8'd3;
    localparam logic [GAIN_W-1:0] INTEG_GAIN_RESET = 8'd12;
    localparam logic [RATE_W-1:0] RATE_RESET       = 8'd10;

    localparam logic [DRIVE_W-1:0]        DRIVE_MAX = 7'd80;
    localparam logic signed [INTEG_W-1:0] INTEG_MAX = 24'sd80;
    localparam logic signed [INTEG_W-1:0] INTEG_MIN = 24'sh800000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPEED_REF,
        CFG_PROP_GAIN,
        CFG_INTEG_GAIN,
        CFG_SAMPLE_RATE
    } t_cfg_idx;

    typedef enum logic [3:0] {
        OP_LOAD,
        OP_MULP,
        OP_DIV10P,
        OP_MULI,
        OP_DIVINIT,
        OP_DIVSTEP,
        OP_DIV10I,
        OP_ADDI,
        OP_FINISH
    } t_op;

    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_WAIT_IN,
        SEQ_LOOP,
        SEQ_WAIT_OUT
    } t_seq;

    typedef struct packed {
        t_op             op;
        t_seq            seq;
        logic [PC_W-1:0] target;
    } t_ctrl;

    localparam logic [PC_W-1:0] PC_START  = 4'd0;
    localparam logic [PC_W-1:0] PC_DIV    = 4'd5;
    localparam logic [PC_W-1:0] PC_FINISH = 4'd8;

    function automatic t_ctrl rom_word(input logic [PC_W-1:0] pc);
        t_ctrl w;
        case (pc)
            4'd0: w = '{op: OP_LOAD,    seq: SEQ_WAIT_IN,  target: PC_START};
            4'd1: w = '{op: OP_MULP,    seq: SEQ_NEXT,     target: PC_START};
            4'd2: w = '{op: OP_DIV10P,  seq: SEQ_NEXT,     target: PC_START};
            4'd3: w = '{op: OP_MULI,    seq: SEQ_NEXT,     target: PC_START};
            4'd4: w = '{op: OP_DIVINIT, seq: SEQ_NEXT,     target: PC_START};
            4'd5: w = '{op: OP_DIVSTEP, seq: SEQ_LOOP,     target: PC_DIV};
            4'd6: w = '{op: OP_DIV10I,  seq: SEQ_NEXT,     target: PC_START};
            4'd7: w = '{op: OP_ADDI,    seq: SEQ_NEXT,     target: PC_START};
            4'd8: w = '{op: OP_FINISH,  seq: SEQ_WAIT_OUT, target: PC_START};
            default: w = '{op: OP_LOAD, seq: SEQ_WAIT_OUT, target: PC_START};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> sv/spc_pulse_if.sv
`default_nettype none

interface spc_pulse_if;
    import spc_pkg::*;

    logic               valid;
    logic               ready;
    logic [PULSE_W-1:0] pulse_count;

    modport source (output valid, output pulse_count, input ready);
    modport sink   (input valid, input pulse_count, output ready);
endinterface

`default_nettype wire

>>> sv/spc_drive_if.sv
`default_nettype none

interface spc_drive_if;
    import spc_pkg::*;

    logic               valid;
    logic               ready;
    logic [DRIVE_W-1:0] drive_percent;
    logic [SPEED_W-1:0] measured_speed;

    modport source (output valid, output drive_percent, output measured_speed, input ready);
    modport sink   (input valid, input drive_percent, input measured_speed, output ready);
endinterface

`default_nettype wire

>>> sv/speed_pi_controller.sv
// A new input is taken only once the sequencer is back at its first step;
// the sequence runs the 24-step restoring divider for the integral increment.
// The result register lets the next input transfer while a result waits.
// Reset (synchronous, active low) loads the register defaults, clears the
// integral and the result valid flag and returns the sequencer to its first step.
`default_nettype none

`include "speed_pi_controller_assert.svh"

module speed_pi_controller (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [spc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [spc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    spc_pulse_if.sink                           i_pulse,
    spc_drive_if.source                         o_drive
);
    import spc_pkg::*;

    logic [REF_W-1:0]  r_speed_ref;
    logic [GAIN_W-1:0] r_prop_gain;
    logic [GAIN_W-1:0] r_integ_gain;
    logic [RATE_W-1:0] r_rate;

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_ctrl           w_ctrl;
    logic            w_go;
    logic            w_in_xfer;
    logic            w_out_free;

    logic signed [ERR_W-1:0]   r_err;
    logic [MAG_W-1:0]          r_mag;
    logic                      r_neg;
    logic signed [TERM_W-1:0]  r_p;
    logic [MAG_W-1:0]          r_quo;
    logic [RATE_W-1:0]         r_rem;
    logic [CNT_W-1:0]          r_cnt;
    logic signed [TERM_W-1:0]  r_inc;
    logic signed [ITERM_W-1:0] r_iterm;
    logic signed [INTEG_W-1:0] r_integ;
    logic [SPEED_W-1:0]        r_speed;

    logic               r_out_valid;
    logic [DRIVE_W-1:0] r_out_drive;
    logic [SPEED_W-1:0] r_out_speed;

    logic [PULSE_W+2:0]        w_speed_x5;
    logic [SPEED_W-1:0]        w_speed;
    logic signed [ERR_W-1:0]   w_err;
    logic [ERR_W-1:0]          w_err_abs;
    logic [EMAG_W-1:0]         w_err_mag;
    logic [GAIN_W-1:0]         w_gain;
    logic [GAIN_W+EMAG_W-1:0]  w_gprod;
    logic [MAG_W-1:0]          w_div10_src;
    logic [RPROD_W-1:0]        w_rprod;
    logic [Q10_W-1:0]          w_q10;
    logic signed [TERM_W-1:0]  w_q10_s;
    logic [RATE_W-1:0]         w_div;
    logic [RATE_W:0]           w_trial;
    logic [RATE_W:0]           w_sub;
    logic                      w_ge;
    logic signed [ITERM_W-1:0] w_iterm;
    logic signed [CTRL_W-1:0]  w_sum;
    logic [DRIVE_W-1:0]        w_drive;
    logic signed [INTEG_W-1:0] w_integ_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_ref  <= SPEED_REF_RESET;
            r_prop_gain  <= PROP_GAIN_RESET;
            r_integ_gain <= INTEG_GAIN_RESET;
            r_rate       <= RATE_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SPEED_REF:   r_speed_ref  <= i_cfg_data[REF_W-1:0];
                CFG_PROP_GAIN:   r_prop_gain  <= i_cfg_data[GAIN_W-1:0];
                CFG_INTEG_GAIN:  r_integ_gain <= i_cfg_data[GAIN_W-1:0];
                CFG_SAMPLE_RATE: r_rate       <= i_cfg_data[RATE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_ctrl        = rom_word(r_pc);
    assign i_pulse.ready = (r_pc == PC_START);
    assign w_in_xfer     = i_pulse.valid & i_pulse.ready;
    assign w_out_free    = !r_out_valid || o_drive.ready;

    always_comb begin
        case (w_ctrl.seq)
            SEQ_NEXT:     w_go = 1'b1;
            SEQ_WAIT_IN:  w_go = w_in_xfer;
            SEQ_LOOP:     w_go = 1'b1;
            SEQ_WAIT_OUT: w_go = w_out_free;
            default:      w_go = 1'b0;
        endcase
        n_pc = r_pc;
        if (w_go) begin
            case (w_ctrl.seq)
                SEQ_NEXT:     n_pc = r_pc + 1'b1;
                SEQ_WAIT_IN:  n_pc = r_pc + 1'b1;
                SEQ_LOOP:     n_pc = (r_cnt != CNT_W'(1)) ? w_ctrl.target : r_pc + 1'b1;
                SEQ_WAIT_OUT: n_pc = w_ctrl.target;
                default:      n_pc = PC_START;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_START;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign w_speed_x5 = {3'b000, i_pulse.pulse_count} + {1'b0, i_pulse.pulse_count, 2'b00};
    assign w_speed    = w_speed_x5[PULSE_W+2:3];
    assign w_err      = $signed({2'b00, r_speed_ref}) - $signed({2'b00, w_speed});

    assign w_err_abs = r_err[ERR_W-1] ? ERR_W'(-r_err) : ERR_W'(r_err);
    assign w_err_mag = w_err_abs[EMAG_W-1:0];
    assign w_gain    = (w_ctrl.op == OP_MULP) ? r_prop_gain : r_integ_gain;
    assign w_gprod   = {{EMAG_W{1'b0}}, w_gain} * {{GAIN_W{1'b0}}, w_err_mag};

    assign w_div10_src = (w_ctrl.op == OP_DIV10P) ? r_mag : r_quo;
    assign w_rprod     = {{(RPROD_W-MAG_W){1'b0}}, w_div10_src} * {{(RPROD_W-32){1'b0}}, RECIP10};
    assign w_q10       = w_rprod[RECIP_SHIFT+Q10_W-1:RECIP_SHIFT];
    assign w_q10_s     = r_neg ? -$signed({1'b0, w_q10}) : $signed({1'b0, w_q10});

    assign w_div   = (r_rate == '0) ? RATE_W'(1) : r_rate;
    assign w_trial = {r_rem, r_quo[MAG_W-1]};
    assign w_ge    = (w_trial >= {1'b0, w_div});
    assign w_sub   = w_trial - {1'b0, w_div};

    assign w_iterm = {r_integ[INTEG_W-1], r_integ}
                   + {{(ITERM_W-TERM_W){r_inc[TERM_W-1]}}, r_inc};
    assign w_sum   = {{(CTRL_W-TERM_W){r_p[TERM_W-1]}}, r_p} + {r_iterm[ITERM_W-1], r_iterm};

    always_comb begin
        if (w_sum >= $signed({{(CTRL_W-DRIVE_W){1'b0}}, DRIVE_MAX})) begin
            w_drive = DRIVE_MAX;
        end else if (w_sum <= $signed(CTRL_W'(0))) begin
            w_drive = '0;
        end else begin
            w_drive = w_sum[DRIVE_W-1:0];
        end
        if (r_iterm > $signed({{(ITERM_W-INTEG_W){1'b0}}, INTEG_MAX})) begin
            w_integ_next = INTEG_MAX;
        end else if (r_iterm < $signed({1'b1, INTEG_MIN})) begin
            w_integ_next = INTEG_MIN;
        end else begin
            w_integ_next = r_iterm[INTEG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            case (w_ctrl.op)
                OP_LOAD: begin
                    r_err   <= w_err;
                    r_speed <= w_speed;
                end
                OP_MULP, OP_MULI: begin
                    r_mag <= w_gprod[MAG_W-1:0];
                    r_neg <= r_err[ERR_W-1];
                end
                OP_DIV10P: r_p <= w_q10_s;
                OP_DIVINIT: begin
                    r_quo <= r_mag;
                    r_rem <= '0;
                    r_cnt <= DIV_STEPS;
                end
                OP_DIVSTEP: begin
                    r_rem <= w_ge ? w_sub[RATE_W-1:0] : w_trial[RATE_W-1:0];
                    r_quo <= {r_quo[MAG_W-2:0], w_ge};
                    r_cnt <= r_cnt - 1'b1;
                end
                OP_DIV10I: r_inc   <= w_q10_s;
                OP_ADDI:   r_iterm <= w_iterm;
                OP_FINISH: begin
                    r_out_drive <= w_drive;
                    r_out_speed <= r_speed;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_go && w_ctrl.op == OP_FINISH) begin
                r_integ     <= w_integ_next;
                r_out_valid <= 1'b1;
            end else if (o_drive.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_drive.valid          = r_out_valid;
    assign o_drive.drive_percent  = r_out_drive;
    assign o_drive.measured_speed = r_out_speed;

    `SPC_ASSERT(a_integ_bound, i_clk, i_rst_n, r_integ <= INTEG_MAX, "integral above limit")
    `SPC_ASSERT(a_drive_bound, i_clk, i_rst_n, o_drive.valid |-> o_drive.drive_percent <= DRIVE_MAX, "drive above limit")
    `SPC_ASSERT(a_rem_bound, i_clk, i_rst_n, (r_pc == PC_DIV) |-> (r_rem < w_div), "divider remainder out of range")
    `SPC_ASSERT(a_valid_src, i_clk, i_rst_n, $rose(r_out_valid) |-> ($past(r_pc) == PC_FINISH), "result without finish step")
    `SPC_ASSERT_ALWAYS(a_ready_idle, i_clk, (i_pulse.ready && i_rst_n) |=> !i_pulse.ready || !$past(i_pulse.valid), "input taken while busy")

endmodule

`default_nettype wire
